FILE: sv/h160_pkg.sv
// Shared types, round constants and helper functions for the HASH160 core.
package h160_pkg;

    typedef struct packed {
        logic [63:0] key_bytes_0_7;
        logic [63:0] key_bytes_8_15;
        logic [63:0] key_bytes_16_23;
        logic [63:0] key_bytes_24_31;
        logic [7:0]  key_byte_32;
    } h160_in_t;

    typedef struct packed {
        logic [63:0] digest_bytes_0_7;
        logic [63:0] digest_bytes_8_15;
        logic [31:0] digest_bytes_16_19;
    } h160_out_t;

    localparam int ShaRounds = 64;
    localparam int RmdRounds = 80;

    localparam logic [31:0] SHA_PAD_WORD  = 32'h0080_0000;
    localparam logic [31:0] SHA_BIT_LEN   = 32'd264;
    localparam logic [31:0] RMD_PAD_WORD  = 32'h0000_0080;
    localparam logic [31:0] RMD_BIT_LEN   = 32'd256;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam int RMD_WL [80] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
        7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
        3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
        1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2,
        4, 0, 5, 9, 7, 12, 2, 10, 14, 1, 3, 8, 11, 6, 15, 13
    };
    localparam int RMD_WR [80] = '{
        5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
        6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
        15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
        8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14,
        12, 15, 10, 4, 1, 5, 8, 7, 6, 2, 13, 14, 0, 3, 9, 11
    };
    localparam int RMD_SL [80] = '{
        11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
        7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
        11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
        11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12,
        9, 15, 5, 11, 6, 8, 13, 12, 5, 12, 13, 14, 11, 8, 5, 6
    };
    localparam int RMD_SR [80] = '{
        8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
        9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
        9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
        15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8,
        8, 5, 12, 9, 12, 5, 14, 6, 8, 13, 6, 5, 15, 13, 11, 11
    };

    localparam logic [31:0] RMD_KL [5] = '{
        32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
    };
    localparam logic [31:0] RMD_KR [5] = '{
        32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
    };
    localparam logic [31:0] RMD_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rmd_f(input int g, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
        logic [31:0] f;
        case (g)
            0:       f = x ^ y ^ z;
            1:       f = (x & y) | (~x & z);
            2:       f = (x | ~y) ^ z;
            3:       f = (x & z) | (y & ~z);
            default: f = x ^ (y | ~z);
        endcase
        return f;
    endfunction

    // Fixed padding words of the RIPEMD-160 message block (message words 8..15).
    function automatic logic [31:0] rmd_pad(input int k);
        logic [31:0] p;
        case (k)
            8:       p = RMD_PAD_WORD;
            14:      p = RMD_BIT_LEN;
            default: p = 32'h0;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/hash160_33_byte_key_core.sv
// HASH160 core: SHA-256 then RIPEMD-160 over a 33-byte key, one round per pipeline stage.
// Takes one 33-byte key per clock unless stalled and returns RIPEMD-160(SHA-256(key)) as a
// 20-byte digest, byte 0 in the top bits of each field. The datapath is a 147-stage pipeline:
// one input register, 64 SHA-256 round stages, a finalize stage, 80 RIPEMD-160 stages
// (left and right lines side by side) and the output register, and one word per cycle
// streams through while the output is not stalled. The whole pipeline advances together;
// it holds while a result waits on m_ready, and bubbles move forward whenever the output
// register is empty or being taken.
module hash160_33_byte_key_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  h160_pkg::h160_in_t  s_data,
    output logic                m_valid,
    output logic                m_ready_unused_n,
    input  logic                m_ready,
    output h160_pkg::h160_out_t m_data
);
    import h160_pkg::*;

    logic en;

    logic        sval_reg [ShaRounds+1];
    logic [31:0] sv_reg   [ShaRounds+1][8];
    logic [31:0] sw_reg   [ShaRounds+1][16];

    logic        rval_reg [RmdRounds+1];
    logic [31:0] lv_reg   [RmdRounds+1][5];
    logic [31:0] rv_reg   [RmdRounds+1][5];
    logic [31:0] x_reg    [RmdRounds+1][8];

    logic        m_valid_reg;
    h160_out_t   m_data_reg;
    logic [31:0] h_next [5];

    assign en               = !m_valid_reg || m_ready;
    assign s_ready          = en;
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;
    assign m_ready_unused_n = 1'b0;

    // Input stage: load the padded SHA-256 block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sval_reg[0] <= 1'b0;
        end else if (en) begin
            sval_reg[0] <= s_valid;
            for (int k = 0; k < 8; k++) begin
                sv_reg[0][k] <= SHA_IV[k];
            end
            sw_reg[0][0]  <= s_data.key_bytes_0_7[63:32];
            sw_reg[0][1]  <= s_data.key_bytes_0_7[31:0];
            sw_reg[0][2]  <= s_data.key_bytes_8_15[63:32];
            sw_reg[0][3]  <= s_data.key_bytes_8_15[31:0];
            sw_reg[0][4]  <= s_data.key_bytes_16_23[63:32];
            sw_reg[0][5]  <= s_data.key_bytes_16_23[31:0];
            sw_reg[0][6]  <= s_data.key_bytes_24_31[63:32];
            sw_reg[0][7]  <= s_data.key_bytes_24_31[31:0];
            sw_reg[0][8]  <= {s_data.key_byte_32, 24'h0} | SHA_PAD_WORD;
            for (int k = 9; k < 15; k++) begin
                sw_reg[0][k] <= 32'h0;
            end
            sw_reg[0][15] <= SHA_BIT_LEN;
        end
    end

    for (genvar i = 0; i < ShaRounds; i++) begin : g_sha
        logic [31:0] t1, t2, wn, a, e;
        assign a  = sv_reg[i][0];
        assign e  = sv_reg[i][4];
        assign t1 = sv_reg[i][7] + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                  + (sv_reg[i][6] ^ (e & (sv_reg[i][5] ^ sv_reg[i][6])))
                  + SHA_K[i] + sw_reg[i][0];
        assign t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
                  + ((a & sv_reg[i][1]) | (sv_reg[i][2] & (a | sv_reg[i][1])));
        // Next schedule word enters at the top of the sliding window.
        assign wn = sw_reg[i][0]
                  + (rotr32(sw_reg[i][1], 7) ^ rotr32(sw_reg[i][1], 18) ^ (sw_reg[i][1] >> 3))
                  + sw_reg[i][9]
                  + (rotr32(sw_reg[i][14], 17) ^ rotr32(sw_reg[i][14], 19)
                     ^ (sw_reg[i][14] >> 10));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sval_reg[i+1] <= 1'b0;
            end else if (en) begin
                sval_reg[i+1]  <= sval_reg[i];
                sv_reg[i+1][0] <= t1 + t2;
                sv_reg[i+1][1] <= sv_reg[i][0];
                sv_reg[i+1][2] <= sv_reg[i][1];
                sv_reg[i+1][3] <= sv_reg[i][2];
                sv_reg[i+1][4] <= sv_reg[i][3] + t1;
                sv_reg[i+1][5] <= sv_reg[i][4];
                sv_reg[i+1][6] <= sv_reg[i][5];
                sv_reg[i+1][7] <= sv_reg[i][6];
                for (int k = 0; k < 15; k++) begin
                    sw_reg[i+1][k] <= sw_reg[i][k+1];
                end
                sw_reg[i+1][15] <= wn;
            end
        end
    end

    // Finalize SHA-256 and swap digest words into RIPEMD-160 message order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rval_reg[0] <= 1'b0;
        end else if (en) begin
            rval_reg[0] <= sval_reg[ShaRounds];
            for (int k = 0; k < 8; k++) begin
                x_reg[0][k] <= swap32(sv_reg[ShaRounds][k] + SHA_IV[k]);
            end
            for (int k = 0; k < 5; k++) begin
                lv_reg[0][k] <= RMD_IV[k];
                rv_reg[0][k] <= RMD_IV[k];
            end
        end
    end

    for (genvar j = 0; j < RmdRounds; j++) begin : g_rmd
        localparam int G  = j / 16;
        localparam int WL = RMD_WL[j];
        localparam int WR = RMD_WR[j];
        logic [31:0] xl, xr, tl, tr;

        if (WL < 8) begin : g_xl_msg
            assign xl = x_reg[j][WL];
        end else begin : g_xl_pad
            assign xl = rmd_pad(WL);
        end
        if (WR < 8) begin : g_xr_msg
            assign xr = x_reg[j][WR];
        end else begin : g_xr_pad
            assign xr = rmd_pad(WR);
        end

        assign tl = rotl32(lv_reg[j][0] + rmd_f(G, lv_reg[j][1], lv_reg[j][2], lv_reg[j][3])
                           + xl + RMD_KL[G], RMD_SL[j]) + lv_reg[j][4];
        assign tr = rotl32(rv_reg[j][0] + rmd_f(4 - G, rv_reg[j][1], rv_reg[j][2], rv_reg[j][3])
                           + xr + RMD_KR[G], RMD_SR[j]) + rv_reg[j][4];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rval_reg[j+1] <= 1'b0;
            end else if (en) begin
                rval_reg[j+1]  <= rval_reg[j];
                x_reg[j+1]     <= x_reg[j];
                lv_reg[j+1][0] <= lv_reg[j][4];
                lv_reg[j+1][1] <= tl;
                lv_reg[j+1][2] <= lv_reg[j][1];
                lv_reg[j+1][3] <= rotl32(lv_reg[j][2], 10);
                lv_reg[j+1][4] <= lv_reg[j][3];
                rv_reg[j+1][0] <= rv_reg[j][4];
                rv_reg[j+1][1] <= tr;
                rv_reg[j+1][2] <= rv_reg[j][1];
                rv_reg[j+1][3] <= rotl32(rv_reg[j][2], 10);
                rv_reg[j+1][4] <= rv_reg[j][3];
            end
        end
    end

    always_comb begin
        h_next[0] = RMD_IV[1] + lv_reg[RmdRounds][2] + rv_reg[RmdRounds][3];
        h_next[1] = RMD_IV[2] + lv_reg[RmdRounds][3] + rv_reg[RmdRounds][4];
        h_next[2] = RMD_IV[3] + lv_reg[RmdRounds][4] + rv_reg[RmdRounds][0];
        h_next[3] = RMD_IV[4] + lv_reg[RmdRounds][0] + rv_reg[RmdRounds][1];
        h_next[4] = RMD_IV[0] + lv_reg[RmdRounds][1] + rv_reg[RmdRounds][2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg                   <= rval_reg[RmdRounds];
            m_data_reg.digest_bytes_0_7   <= {swap32(h_next[0]), swap32(h_next[1])};
            m_data_reg.digest_bytes_8_15  <= {swap32(h_next[2]), swap32(h_next[3])};
            m_data_reg.digest_bytes_16_19 <= swap32(h_next[4]);
        end
    end

    a_reset_clears : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");
    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> sval_reg[0])
        else $error("accepted word missing from input stage");
    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(rval_reg[RmdRounds]) && $stable(sval_reg[ShaRounds]))
        else $error("pipeline moved during stall");

endmodule

FILE: verif/tb_hash160_33_byte_key_core.sv
// Testbench for the HASH160 core: directed keys, then random keys under varied flow control.
module tb_hash160_33_byte_key_core;
    import h160_pkg::*;

    localparam int PipeDepth = 147;
    localparam int IdleLimit = 20000;
    localparam int RandomKeys = 900;

    typedef enum int {
        PH_STREAM,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } phase_e;

    typedef struct {
        h160_in_t  key;
        logic      known;
        h160_out_t digest;
    } key_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    h160_in_t  s_data;
    logic      m_valid;
    logic      m_ready_unused_n;
    logic      m_ready;
    h160_out_t m_data;

    h160_out_t digest_q[$];
    int        mismatches;
    int        digests_seen;
    int        keys_sent;
    int        idle_cycles;
    int        src_idle_pct;
    int        sink_stall_pct;
    logic      timed_out;
    key_row_t  key_rows[$];

    hash160_33_byte_key_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready_unused_n(m_ready_unused_n),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] byte_rev(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rmd_bool(input int g, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z);
        case (g)
            0: return x ^ y ^ z;
            1: return (x & y) | (~x & z);
            2: return (x | ~y) ^ z;
            3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    // SHA-256 over the padded 33-byte key, then RIPEMD-160 over the 32-byte digest.
    function automatic h160_out_t hash160_of(input h160_in_t k);
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] sd[8];
        logic [31:0] x[16];
        logic [31:0] l[5];
        logic [31:0] r[5];
        logic [31:0] rd[5];
        logic [31:0] s0, s1, t1, t2, e, a, t;
        logic [255:0] msg;
        int g;
        msg = {k.key_bytes_0_7, k.key_bytes_8_15, k.key_bytes_16_23, k.key_bytes_24_31};
        for (int i = 0; i < 8; i++) w[i] = msg[255 - 32*i -: 32];
        w[8] = {k.key_byte_32, 24'h0} | SHA_PAD_WORD;
        for (int i = 9; i < 15; i++) w[i] = '0;
        w[15] = SHA_BIT_LEN;
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = SHA_IV[i];
        for (int i = 0; i < 64; i++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + (v[6] ^ (e & (v[5] ^ v[6])))
                 + SHA_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) | (v[2] & (a | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) sd[i] = v[i] + SHA_IV[i];
        // RIPEMD-160 takes its message words little-endian
        for (int i = 0; i < 8; i++) x[i] = byte_rev(sd[i]);
        for (int i = 8; i < 16; i++) x[i] = '0;
        x[8] = RMD_PAD_WORD;
        x[14] = RMD_BIT_LEN;
        for (int j = 0; j < 5; j++) begin
            l[j] = RMD_IV[j];
            r[j] = RMD_IV[j];
        end
        for (int j = 0; j < 80; j++) begin
            g = j / 16;
            t = rol(l[0] + rmd_bool(g, l[1], l[2], l[3]) + x[RMD_WL[j]] + RMD_KL[g], RMD_SL[j])
                + l[4];
            l[0] = l[4]; l[4] = l[3]; l[3] = rol(l[2], 10); l[2] = l[1]; l[1] = t;
            t = rol(r[0] + rmd_bool(4 - g, r[1], r[2], r[3]) + x[RMD_WR[j]] + RMD_KR[g],
                    RMD_SR[j]) + r[4];
            r[0] = r[4]; r[4] = r[3]; r[3] = rol(r[2], 10); r[2] = r[1]; r[1] = t;
        end
        rd[0] = RMD_IV[1] + l[2] + r[3];
        rd[1] = RMD_IV[2] + l[3] + r[4];
        rd[2] = RMD_IV[3] + l[4] + r[0];
        rd[3] = RMD_IV[4] + l[0] + r[1];
        rd[4] = RMD_IV[0] + l[1] + r[2];
        return '{digest_bytes_0_7:   {byte_rev(rd[0]), byte_rev(rd[1])},
                 digest_bytes_8_15:  {byte_rev(rd[2]), byte_rev(rd[3])},
                 digest_bytes_16_19: byte_rev(rd[4])};
    endfunction

    function automatic h160_in_t random_key();
        h160_in_t k;
        k.key_bytes_0_7   = {$urandom, $urandom};
        k.key_bytes_8_15  = {$urandom, $urandom};
        k.key_bytes_16_23 = {$urandom, $urandom};
        k.key_bytes_24_31 = {$urandom, $urandom};
        k.key_byte_32     = 8'($urandom);
        // compressed keys start with 02 or 03, but any prefix is hashed
        case ($urandom_range(3))
            0: k.key_bytes_0_7[63:56] = 8'h02;
            1: k.key_bytes_0_7[63:56] = 8'h03;
            default: ;
        endcase
        return k;
    endfunction

    task automatic add_row(input h160_in_t k, input logic known, input h160_out_t d);
        key_row_t row;
        row.key = k;
        row.known = known;
        row.digest = d;
        key_rows.push_back(row);
    endtask

    // Drive one key; the sender may idle before raising valid.
    task automatic send_key(input h160_in_t k, input h160_out_t d);
        while (($urandom_range(99)) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= k;
        digest_q.push_back(d);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        keys_sent++;
    endtask

    task automatic set_phase(input phase_e p);
        case (p)
            PH_STREAM:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            PH_SRC_IDLE:   begin src_idle_pct = 67; sink_stall_pct = 0;  end
            PH_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 67; end
            default:       begin src_idle_pct = 14; sink_stall_pct = 14; end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each digest word against the oldest pending prediction.
    always @(posedge aclk) begin
        h160_out_t want;
        if (aresetn && m_valid && m_ready) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest word %h", m_data);
            end else begin
                want = digest_q.pop_front();
                if (m_data.digest_bytes_0_7 !== want.digest_bytes_0_7 ||
                    m_data.digest_bytes_8_15 !== want.digest_bytes_8_15 ||
                    m_data.digest_bytes_16_19 !== want.digest_bytes_16_19) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h_%h_%h got %h_%h_%h",
                                 want.digest_bytes_0_7, want.digest_bytes_8_15,
                                 want.digest_bytes_16_19, m_data.digest_bytes_0_7,
                                 m_data.digest_bytes_8_15, m_data.digest_bytes_16_19);
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog expired after %0d idle cycles", IdleLimit);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        h160_in_t k;
        h160_out_t none;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        keys_sent = 0;
        timed_out = 1'b0;
        set_phase(PH_STREAM);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed keys: all zero, all ones, prefix variants, single-bit walks.
        add_row('0, 1'b0, none);
        add_row('1, 1'b0, none);
        k = '0; k.key_bytes_0_7[63:56] = 8'h02; add_row(k, 1'b0, none);
        k = '0; k.key_bytes_0_7[63:56] = 8'h03; add_row(k, 1'b0, none);
        k = '1; k.key_bytes_0_7[63:56] = 8'h04; add_row(k, 1'b0, none);
        k = '0; k.key_byte_32 = 8'hFF; add_row(k, 1'b0, none);
        k = '1; k.key_byte_32 = 8'h00; add_row(k, 1'b0, none);
        // generator point as a compressed key, with its published digest
        k = '0;
        k.key_bytes_0_7   = 64'h0279BE667EF9DCBB;
        k.key_bytes_8_15  = 64'hAC55A06295CE870B;
        k.key_bytes_16_23 = 64'h07029BFCDB2DCE28;
        k.key_bytes_24_31 = 64'hD959F2815B16F817;
        k.key_byte_32     = 8'h98;
        add_row(k, 1'b1, '{digest_bytes_0_7: 64'h751e76e8199196d4,
                           digest_bytes_8_15: 64'h54941c45d1b3a323,
                           digest_bytes_16_19: 32'hf1433bd6});
        for (int b = 0; b < 264; b += 19) begin
            k = '0;
            k[b] = 1'b1;
            add_row(k, 1'b0, none);
        end
        foreach (key_rows[i])
            send_key(key_rows[i].key,
                     key_rows[i].known ? key_rows[i].digest : hash160_of(key_rows[i].key));

        for (int n = 0; n < RandomKeys; n++) begin
            if (n % 150 == 0) set_phase(phase_e'((n / 150) % 4));
            // drain the pipe once so a burst starts from empty
            if (n == 450) begin
                s_valid <= 1'b0;
                wait (digest_q.size() == 0);
            end
            k = random_key();
            send_key(k, hash160_of(k));
        end
        s_valid <= 1'b0;

        fork
            wait (digest_q.size() == 0);
            begin
                repeat (IdleLimit) @(posedge aclk);
                timed_out = 1'b1;
            end
        join_any
        disable fork;
        repeat (PipeDepth + 20) @(posedge aclk);

        $display("sent %0d keys (directed and random), checked %0d digests, %0d mismatches",
                 keys_sent, digests_seen, mismatches);
        $display("flow control: streaming, sender idle, receiver stall and mixed phases");
        if (timed_out || mismatches != 0 || digest_q.size() != 0) begin
            $display("status: fail");
        end else begin
            $display("status: pass");
        end
        $finish;
    end

endmodule
